### src/brtm_pkg.sv
// Shared types and constants of the banded temperature motor regulator.
// Holds band codes, register indexes, the volume scaling constants and sideband structs.
// No dependencies.
`default_nettype none

package brtm_pkg;

  localparam int SPEED_W    = 8;
  localparam int BAND_CFG_W = 8;
  localparam int IVAL_W     = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_LIMIT_ONE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LIMIT_TWO = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SETPOINT  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BAND      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_INTERVAL  = 3'd4;

  // Band classification of one sample, slope test already folded in
  localparam int BAND_CODE_W = 3;
  typedef logic [BAND_CODE_W-1:0] band_t;
  localparam band_t BAND_HOLD       = 3'd0;
  localparam band_t BAND_HOT_MAX    = 3'd1;
  localparam band_t BAND_HOT_BIG    = 3'd2;
  localparam band_t BAND_HOT_SMALL  = 3'd3;
  localparam band_t BAND_COLD_MAX   = 3'd4;
  localparam band_t BAND_COLD_BIG   = 3'd5;
  localparam band_t BAND_COLD_SMALL = 3'd6;

  // Queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_PTR_W = 2;

  // Volume arithmetic: step = floor(elapsed * speed * 2048 / 266625)
  // (32768 / 4266000 reduced by 16). Quotient by reciprocal with one correction.
  localparam int STEP_W    = 32;
  localparam int VOL_W     = 48;
  localparam int ELAPSED_W = 32;
  localparam int PROD_W    = ELAPSED_W + SPEED_W;
  localparam int VOL_SHIFT = 11;
  localparam int SCALED_W  = PROD_W + VOL_SHIFT;
  localparam int DIV_W     = 19;
  localparam logic [DIV_W-1:0] VOL_DIV = 19'd266625;
  localparam int RECIP_W   = 34;
  localparam logic [RECIP_W-1:0] VOL_RECIP =
    RECIP_W'((64'd1 << (PROD_W + VOL_SHIFT)) / 64'd266625);
  localparam int P_LO_W    = 20;
  localparam int R_LO_W    = 17;
  localparam int PP_W      = 37;
  localparam int SB_W      = PP_W + 4;
  localparam int SUM_W     = PROD_W + RECIP_W;
  localparam int QE_W      = SUM_W - PROD_W;

  localparam int OUT_DW    = 104;

  typedef struct packed {
    logic [SPEED_W-1:0] applied;
    logic [SPEED_W-1:0] wanted;
    logic               changed;
  } res_info_t;

  typedef struct packed {
    logic [SPEED_W-1:0] limit_one;
    logic [SPEED_W-1:0] limit_two;
    logic [IVAL_W-1:0]  interval;
  } back_cfg_t;

endpackage

`default_nettype wire

### src/banded_temperature_motor_regulator_core.sv
// Top level of the banded temperature motor regulator.
// Holds the configuration registers and ties front end, queue and back end.
// Depends on brtm_pkg, brtm_front, brtm_fifo, brtm_back.
`default_nettype none

// One request on the input stream carries a temperature sample and a
// millisecond time stamp; each one yields exactly one result. The sample is
// sorted into a band around the setpoint (edges at 1, 2 and 4 band widths),
// the slope against the previous sample is checked, and the result goes into
// a four-entry queue. The back end turns the band into a target speed,
// clamps it to the smaller and larger of the two limit registers and applies
// it only when it differs from the running speed and more than the
// correction interval has passed (wrapping time difference). Each correction
// adds the volume pumped at the old speed, in cm3 with 8 fraction bits, to a
// saturating 48-bit total. Throughput is one request per clock while the
// output is not stalled; each speed decision is registered and used by the
// next entry. The queue write happens on the accepting edge; the queue read
// and speed decision feed a register, then six volume pipeline stages
// (multiply, reciprocal partial products, two adds, remainder multiply,
// fix-up) and the output register, which also carries the total.
// A stalled output holds the whole back end; the queue then
// absorbs up to four further requests before in_tready drops. Configuration
// is written through cfg_we / cfg_index / cfg_wdata and must only change
// while no request is in flight; indexes beyond the register list are dropped.
module banded_temperature_motor_regulator_core #(
  parameter int TEMP_WIDTH = 12,
  parameter int TIME_WIDTH = 32,
  localparam int IN_DW = ((TEMP_WIDTH + TIME_WIDTH + 7) / 8) * 8
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // input stream
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // in_tdata, low bit first: temperature, time_ms, zero fill
  input  logic [IN_DW-1:0]                  in_tdata,
  // result stream
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // out_tdata, low bit first: applied_speed[7:0], wanted_speed[7:0],
  // speed_changed, volume_step[31:0], volume_total[47:0], zero fill
  output logic [brtm_pkg::OUT_DW-1:0]       out_tdata,
  // configuration write port
  input  logic                              cfg_we,
  input  logic [brtm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [brtm_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import brtm_pkg::*;

  localparam int ENTRY_W = TIME_WIDTH + BAND_CODE_W;
  localparam int PAD_W   = OUT_DW - (2 * SPEED_W + 1 + STEP_W + VOL_W);

  // configuration registers
  logic [SPEED_W-1:0]           lim_one_r, lim_two_r;
  logic signed [TEMP_WIDTH-1:0] setpoint_r;
  logic [BAND_CFG_W-1:0]        band_r;
  logic [IVAL_W-1:0]            interval_r;

  logic                         q_push, q_full, q_valid, q_pop;
  logic [ENTRY_W-1:0]           q_wdata, q_rdata;
  back_cfg_t                    back_cfg;
  res_info_t                    res_info;
  logic [STEP_W-1:0]            res_step;
  logic [VOL_W-1:0]             res_total;

  // register writes; unknown indexes drop
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lim_one_r  <= 8'd255;
      lim_two_r  <= 8'd0;
      setpoint_r <= '0;
      band_r     <= 8'd1;
      interval_r <= 16'd10000;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_LIMIT_ONE: lim_one_r  <= cfg_wdata[SPEED_W-1:0];
        REG_LIMIT_TWO: lim_two_r  <= cfg_wdata[SPEED_W-1:0];
        REG_SETPOINT:  setpoint_r <= $signed(cfg_wdata[TEMP_WIDTH-1:0]);
        REG_BAND:      band_r     <= cfg_wdata[BAND_CFG_W-1:0];
        REG_INTERVAL:  interval_r <= cfg_wdata[IVAL_W-1:0];
        default: ;
      endcase
    end
  end

  assign back_cfg.limit_one = lim_one_r;
  assign back_cfg.limit_two = lim_two_r;
  assign back_cfg.interval  = interval_r;

  // classify each sample and hand it on through the queue
  brtm_front #(
    .TEMP_WIDTH (TEMP_WIDTH),
    .TIME_WIDTH (TIME_WIDTH)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_tvalid),
    .in_ready    (in_tready),
    .temperature ($signed(in_tdata[TEMP_WIDTH-1:0])),
    .time_ms     (in_tdata[TEMP_WIDTH +: TIME_WIDTH]),
    .setpoint    (setpoint_r),
    .band_width  (band_r),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_data      (q_wdata)
  );

  brtm_fifo #(
    .WIDTH (ENTRY_W)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .wr_data  (q_wdata),
    .full     (q_full),
    .pop      (q_pop),
    .rd_valid (q_valid),
    .rd_data  (q_rdata)
  );

  // speed decision, volume pipeline and output register
  brtm_back #(
    .TIME_WIDTH (TIME_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (back_cfg),
    .q_valid   (q_valid),
    .q_data    (q_rdata),
    .q_pop     (q_pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_info  (res_info),
    .out_step  (res_step),
    .out_total (res_total)
  );

  assign out_tdata = {{PAD_W{1'b0}}, res_total, res_step, res_info.changed,
                      res_info.wanted, res_info.applied};

  // a correction always lands on the wanted speed
  a_applied_is_wanted: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && res_info.changed |-> res_info.applied == res_info.wanted)
    else $error("applied speed differs from wanted speed on a correction");

  // no correction, no volume
  a_step_only_on_change: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !res_info.changed |-> res_step == '0)
    else $error("volume step without a correction");

  // the target is always within the limits
  a_wanted_in_limits: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (res_info.wanted <= lim_one_r || res_info.wanted <= lim_two_r) &&
                   (res_info.wanted >= lim_one_r || res_info.wanted >= lim_two_r))
    else $error("wanted speed outside the speed limits");

endmodule

`default_nettype wire

### src/brtm_front.sv
// Front end: accepts samples, classifies them into a temperature band.
// Tracks the previous sample for the slope test. Depends on brtm_pkg.
`default_nettype none

module brtm_front #(
  parameter int TEMP_WIDTH = 12,
  parameter int TIME_WIDTH = 32
) (
  input  logic                                        clk,
  input  logic                                        rst_n,
  input  logic                                        in_valid,
  output logic                                        in_ready,
  input  logic signed [TEMP_WIDTH-1:0]                temperature,
  input  logic [TIME_WIDTH-1:0]                       time_ms,
  input  logic signed [TEMP_WIDTH-1:0]                setpoint,
  input  logic [brtm_pkg::BAND_CFG_W-1:0]             band_width,
  input  logic                                        q_full,
  output logic                                        q_push,
  output logic [TIME_WIDTH+brtm_pkg::BAND_CODE_W-1:0] q_data
);
  import brtm_pkg::*;

  localparam int CW = TEMP_WIDTH + BAND_CFG_W + 3;

  logic signed [TEMP_WIDTH-1:0] prev_temp_r;
  logic signed [CW-1:0] t_x, s_x, g1, g2, g4;
  logic rising, falling;
  band_t code;

  assign in_ready = !q_full;
  assign q_push   = in_valid && in_ready;

  always_comb begin
    t_x = {{(CW-TEMP_WIDTH){temperature[TEMP_WIDTH-1]}}, temperature};
    s_x = {{(CW-TEMP_WIDTH){setpoint[TEMP_WIDTH-1]}}, setpoint};
    g1  = $signed({{(CW-BAND_CFG_W){1'b0}}, band_width});
    g2  = g1 <<< 1;
    g4  = g1 <<< 2;
    rising  = temperature > prev_temp_r;
    falling = temperature < prev_temp_r;
    code = BAND_HOLD;
    priority if (t_x > s_x + g4) begin
      code = BAND_HOT_MAX;
    end else if (t_x > s_x + g2) begin
      code = rising ? BAND_HOT_BIG : BAND_HOLD;
    end else if (t_x > s_x + g1) begin
      code = rising ? BAND_HOT_SMALL : BAND_HOLD;
    end else if (t_x < s_x - g4) begin
      code = BAND_COLD_MAX;
    end else if (t_x < s_x - g2) begin
      code = falling ? BAND_COLD_BIG : BAND_HOLD;
    end else if (t_x < s_x - g1) begin
      code = falling ? BAND_COLD_SMALL : BAND_HOLD;
    end else begin
      code = BAND_HOLD;
    end
  end

  assign q_data = {time_ms, code};

  // every accepted sample becomes the previous one
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_temp_r <= '0;
    end else if (q_push) begin
      prev_temp_r <= temperature;
    end
  end

endmodule

`default_nettype wire

### src/brtm_fifo.sv
// Short register queue between the front and back ends.
// Push and pop may happen in the same cycle. Depends on brtm_pkg.
`default_nettype none

module brtm_fifo #(
  parameter int WIDTH = 35
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             pop,
  output logic             rd_valid,
  output logic [WIDTH-1:0] rd_data
);
  import brtm_pkg::*;

  localparam int CNT_W = QUEUE_PTR_W + 1;

  logic [WIDTH-1:0]       mem_r [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]       count_r, count_nxt;
  logic                   do_push, do_pop;

  assign full     = count_r == CNT_W'(QUEUE_DEPTH);
  assign rd_valid = count_r != '0;
  assign rd_data  = mem_r[rd_ptr_r];
  assign do_push  = push && !full;
  assign do_pop   = pop && rd_valid;

  always_comb begin
    count_nxt = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + QUEUE_PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + QUEUE_PTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

`default_nettype wire

### src/brtm_volume.sv
// Pumped volume pipeline: elapsed * speed scaled by 2048/266625, six stages.
// Reciprocal multiply in partial products, then one compare-and-fix step.
// Depends on brtm_pkg.
`default_nettype none

module brtm_volume (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          in_valid,
  input  brtm_pkg::res_info_t           in_info,
  input  logic [brtm_pkg::ELAPSED_W-1:0] in_elapsed,
  input  logic [brtm_pkg::SPEED_W-1:0]  in_speed,
  output logic                          out_valid,
  output brtm_pkg::res_info_t           out_info,
  output logic [brtm_pkg::STEP_W-1:0]   out_step
);
  import brtm_pkg::*;

  localparam int NSTG = 6;

  logic [NSTG-1:0] vld_r;
  res_info_t       info_r [NSTG];

  logic [PROD_W-1:0]   p1_r, p2_r, p3_r, p4_r, p5_r;
  logic [PP_W-1:0]     pp_hh_r, pp_hl_r, pp_lh_r, pp_ll_r;
  logic [SUM_W-1:0]    sa_r;
  logic [SB_W-1:0]     sb_r;
  logic [QE_W-1:0]     qe4_r;
  logic [SCALED_W-1:0] qd5_r;
  logic [STEP_W-1:0]   q5_r;
  logic                sat5_r;
  logic [STEP_W-1:0]   step6_r;

  logic [SUM_W-1:0]    total;
  logic [SCALED_W-1:0] rem;
  logic                sat4;

  always_comb begin
    total = sa_r + (SUM_W'(sb_r) << R_LO_W);
    sat4  = (|qe4_r[QE_W-1:STEP_W]) || (&qe4_r[STEP_W-1:0]);
    rem   = {p5_r, {VOL_SHIFT{1'b0}}} - qd5_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NSTG-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      info_r[0] <= in_info;
      for (int i = 1; i < NSTG; i++) begin
        info_r[i] <= info_r[i-1];
      end
      // product of elapsed time and old speed
      p1_r    <= PROD_W'(in_elapsed) * PROD_W'(in_speed);
      // partial products against the reciprocal
      pp_hh_r <= PP_W'(p1_r[PROD_W-1:P_LO_W]) * PP_W'(VOL_RECIP[RECIP_W-1:R_LO_W]);
      pp_hl_r <= PP_W'(p1_r[PROD_W-1:P_LO_W]) * PP_W'(VOL_RECIP[R_LO_W-1:0]);
      pp_lh_r <= PP_W'(p1_r[P_LO_W-1:0]) * PP_W'(VOL_RECIP[RECIP_W-1:R_LO_W]);
      pp_ll_r <= PP_W'(p1_r[P_LO_W-1:0]) * PP_W'(VOL_RECIP[R_LO_W-1:0]);
      p2_r    <= p1_r;
      // high and low products do not overlap; the cross terms share a shift
      sa_r    <= {pp_hh_r, pp_ll_r};
      sb_r    <= SB_W'({pp_hl_r, 3'b000}) + SB_W'(pp_lh_r);
      p3_r    <= p2_r;
      // quotient estimate, at most one short
      qe4_r   <= total[SUM_W-1:PROD_W];
      p4_r    <= p3_r;
      qd5_r   <= SCALED_W'(qe4_r[STEP_W-1:0]) * SCALED_W'(VOL_DIV);
      q5_r    <= qe4_r[STEP_W-1:0];
      sat5_r  <= sat4;
      p5_r    <= p4_r;
      // fix the estimate up by one where the remainder allows, then saturate
      if (sat5_r) begin
        step6_r <= '1;
      end else begin
        step6_r <= q5_r + STEP_W'(rem >= SCALED_W'(VOL_DIV));
      end
    end
  end

  assign out_valid = vld_r[NSTG-1];
  assign out_info  = info_r[NSTG-1];
  assign out_step  = step6_r;

endmodule

`default_nettype wire

### src/brtm_back.sv
// Back end: applies band decisions to the motor speed state, runs the volume
// pipeline and accumulates the total into the output register.
// Depends on brtm_pkg and brtm_volume.
`default_nettype none

module brtm_back #(
  parameter int TIME_WIDTH = 32
) (
  input  logic                                        clk,
  input  logic                                        rst_n,
  input  brtm_pkg::back_cfg_t                         cfg,
  input  logic                                        q_valid,
  input  logic [TIME_WIDTH+brtm_pkg::BAND_CODE_W-1:0] q_data,
  output logic                                        q_pop,
  output logic                                        out_valid,
  input  logic                                        out_ready,
  output brtm_pkg::res_info_t                         out_info,
  output logic [brtm_pkg::STEP_W-1:0]                 out_step,
  output logic [brtm_pkg::VOL_W-1:0]                  out_total
);
  import brtm_pkg::*;

  localparam int ENTRY_W = TIME_WIDTH + BAND_CODE_W;
  localparam int SX_W    = SPEED_W + 2;

  band_t                   ent_band;
  logic [TIME_WIDTH-1:0]   ent_time, elapsed;
  logic                    adv, chg;
  logic [SPEED_W-1:0]      cur_r, last_hi, last_lo, d_full, d_half, want;
  logic [TIME_WIDTH-1:0]   last_r;
  logic signed [SX_W-1:0]  cur_x, want_raw, hi_x, lo_x;

  logic                    s1_valid_r;
  res_info_t               s1_info_r;
  logic [ELAPSED_W-1:0]    s1_elapsed_r;
  logic [SPEED_W-1:0]      s1_speed_r;

  logic                    vol_valid;
  res_info_t               vol_info;
  logic [STEP_W-1:0]       vol_step;

  logic                    out_valid_r;
  res_info_t               out_info_r;
  logic [STEP_W-1:0]       out_step_r;
  logic [VOL_W-1:0]        acc_r, acc_nxt;
  logic [VOL_W:0]          acc_sum;

  assign ent_band = q_data[BAND_CODE_W-1:0];
  assign ent_time = q_data[ENTRY_W-1:BAND_CODE_W];

  // the whole back pipeline moves as one while the output slot can take a result
  assign adv   = !out_valid_r || out_ready;
  assign q_pop = adv && q_valid;

  always_comb begin
    last_hi = (cfg.limit_one > cfg.limit_two) ? cfg.limit_one : cfg.limit_two;
    last_lo = (cfg.limit_one > cfg.limit_two) ? cfg.limit_two : cfg.limit_one;
    d_full  = (last_hi - last_lo) >> 1;
    d_half  = d_full >> 1;
    cur_x   = $signed({2'b00, cur_r});
    hi_x    = $signed({2'b00, last_hi});
    lo_x    = $signed({2'b00, last_lo});
    unique case (ent_band)
      BAND_HOT_MAX:    want_raw = lo_x;
      BAND_HOT_BIG:    want_raw = cur_x - $signed({2'b00, d_full});
      BAND_HOT_SMALL:  want_raw = cur_x - $signed({2'b00, d_half});
      BAND_COLD_MAX:   want_raw = hi_x;
      BAND_COLD_BIG:   want_raw = cur_x + $signed({2'b00, d_full});
      BAND_COLD_SMALL: want_raw = cur_x + $signed({2'b00, d_half});
      default:         want_raw = cur_x;
    endcase
    if (want_raw > hi_x) begin
      want = last_hi;
    end else if (want_raw < lo_x) begin
      want = last_lo;
    end else begin
      want = want_raw[SPEED_W-1:0];
    end
    elapsed = ent_time - last_r;
    chg     = (want != cur_r) && (elapsed > TIME_WIDTH'(cfg.interval));
  end

  // speed state: one decision per popped entry, in arrival order
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r      <= '0;
      last_r     <= '0;
      s1_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r <= q_valid;
      if (q_valid && chg) begin
        cur_r  <= want;
        last_r <= ent_time;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_info_r.applied <= chg ? want : cur_r;
      s1_info_r.wanted  <= want;
      s1_info_r.changed <= chg;
      s1_elapsed_r      <= ELAPSED_W'(elapsed);
      // zero speed yields a zero step when nothing is corrected
      s1_speed_r        <= chg ? cur_r : '0;
    end
  end

  brtm_volume u_volume (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (adv),
    .in_valid   (s1_valid_r),
    .in_info    (s1_info_r),
    .in_elapsed (s1_elapsed_r),
    .in_speed   (s1_speed_r),
    .out_valid  (vol_valid),
    .out_info   (vol_info),
    .out_step   (vol_step)
  );

  always_comb begin
    acc_sum = {1'b0, acc_r} + (VOL_W+1)'(vol_step);
    acc_nxt = acc_sum[VOL_W] ? '1 : acc_sum[VOL_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      acc_r       <= '0;
    end else if (adv) begin
      out_valid_r <= vol_valid;
      if (vol_valid) begin
        acc_r <= acc_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && vol_valid) begin
      out_info_r <= vol_info;
      out_step_r <= vol_step;
    end
  end

  always_comb begin
    out_total = acc_r;
    out_valid = out_valid_r;
    out_info  = out_info_r;
    out_step  = out_step_r;
  end

endmodule

`default_nettype wire

### tb/banded_temperature_motor_regulator_core_tb.sv
// Self-checking bench for the banded temperature motor regulator core.
// Drives sample requests, predicts each speed report and compares it field by field.
// Depends on brtm_pkg and banded_temperature_motor_regulator_core.
`default_nettype none

module banded_temperature_motor_regulator_core_tb;
  import brtm_pkg::*;

  localparam int TEMP_W      = 12;
  localparam int TIME_W      = 32;
  localparam int IN_W        = ((TEMP_W + TIME_W + 7) / 8) * 8;
  localparam int TEMP_MAX    = (1 << (TEMP_W - 1)) - 1;
  localparam int TEMP_MIN    = -(1 << (TEMP_W - 1));
  // Settle time after a drain, scaled from the input-to-result latency.
  localparam int LATENCY     = 8;
  localparam int SETTLE      = 2 * LATENCY;
  localparam int MAX_PAUSE   = 12;
  localparam int PHASES      = 10;
  localparam int PHASE_ITEMS = 110;
  localparam int HOLD_CYCLES = 80;

  // One speed report as it leaves the block.
  typedef struct packed {
    logic [SPEED_W-1:0] applied;
    logic [SPEED_W-1:0] wanted;
    logic               changed;
    logic [STEP_W-1:0]  step;
    logic [VOL_W-1:0]   total;
  } speed_report_t;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_W-1:0]       in_tdata   = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DW-1:0]     out_tdata;
  logic                  cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index  = REG_LIMIT_ONE;
  logic [CFG_DATA_W-1:0] cfg_wdata  = '0;

  // Register copies held by the predictor
  logic [SPEED_W-1:0]    lim_one;
  logic [SPEED_W-1:0]    lim_two;
  int                    set_point;
  logic [BAND_CFG_W-1:0] band_width;
  logic [IVAL_W-1:0]     fix_interval;

  // Regulator state held by the predictor
  logic [SPEED_W-1:0]    speed_now;
  int                    temp_before;
  logic [TIME_W-1:0]     last_fix_ms;
  logic [VOL_W-1:0]      volume_sum;

  speed_report_t         expected_reports[$];
  int                    fail_count    = 0;
  bit                    tx_no_idle    = 1'b0;
  bit                    rx_no_idle    = 1'b0;
  int                    sink_hold_req = 0;
  int                    sink_wait     = 0;
  logic [TIME_W-1:0]     clock_ms;

  banded_temperature_motor_regulator_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // ---------------------------------------------------------------------
  // Predictor: band decision, clamp, interval gate and volume accounting.
  // ---------------------------------------------------------------------
  function automatic void reset_regulator();
    lim_one      = 8'd255;
    lim_two      = 8'd0;
    set_point    = 0;
    band_width   = 8'd1;
    fix_interval = 16'd10000;
    speed_now    = '0;
    temp_before  = 0;
    last_fix_ms  = '0;
    volume_sum   = '0;
  endfunction

  function automatic speed_report_t regulate_sample(logic signed [TEMP_W-1:0] temp,
                                                    logic [TIME_W-1:0] stamp);
    int                t;
    int                g;
    int                hi;
    int                lo;
    int                d;
    int                want;
    logic [TIME_W-1:0] elapsed;
    longint unsigned   raw;
    longint unsigned   acc;
    logic [STEP_W-1:0] step;
    speed_report_t     rep;
    t    = temp;
    g    = band_width;
    hi   = (lim_one > lim_two) ? lim_one : lim_two;
    lo   = (lim_one > lim_two) ? lim_two : lim_one;
    d    = (hi - lo) / 2;
    want = speed_now;
    step = '0;
    rep.changed = 1'b0;
    // Hot side steps down, cold side steps up; the slope test only gates
    // the inner bands.
    if (t > set_point + 4 * g) begin
      want = lo;
    end else if (t > set_point + 2 * g) begin
      if (t > temp_before) want = want - d;
    end else if (t > set_point + g) begin
      if (t > temp_before) want = want - d / 2;
    end else if (t < set_point - 4 * g) begin
      want = hi;
    end else if (t < set_point - 2 * g) begin
      if (t < temp_before) want = want + d;
    end else if (t < set_point - g) begin
      if (t < temp_before) want = want + d / 2;
    end
    if (want > hi) want = hi;
    if (want < lo) want = lo;
    temp_before = t;

    // Wrapping time difference; the gate is strictly greater.
    elapsed = stamp - last_fix_ms;
    if (want != int'(speed_now) && elapsed > fix_interval) begin
      raw  = elapsed;
      raw  = raw * speed_now * 64'd32768 / 64'd4266000;
      step = (raw > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : raw[STEP_W-1:0];
      acc  = volume_sum;
      acc  = acc + step;
      if (acc > 64'hFFFF_FFFF_FFFF) acc = 64'hFFFF_FFFF_FFFF;
      volume_sum  = acc[VOL_W-1:0];
      speed_now   = want[SPEED_W-1:0];
      last_fix_ms = stamp;
      rep.changed = 1'b1;
    end
    rep.applied = speed_now;
    rep.wanted  = want[SPEED_W-1:0];
    rep.step    = step;
    rep.total   = volume_sum;
    return rep;
  endfunction

  // ---------------------------------------------------------------------
  // Result sink: pause before each result, honor long hold-off requests.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      sink_wait = 0;
    end else begin
      if (sink_hold_req > 0) begin
        sink_wait = sink_hold_req;
        sink_hold_req = 0;
      end else if (out_tvalid && out_tready) begin
        sink_wait = rx_no_idle ? 0 : $urandom_range(0, MAX_PAUSE);
      end
      if (sink_wait > 0) begin
        out_tready <= 1'b0;
        sink_wait--;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Checker: compare each accepted result with the oldest expectation.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin : check_results
    speed_report_t got;
    speed_report_t exp_rep;
    if (rst_n && out_tvalid && out_tready) begin
      got.applied = out_tdata[7:0];
      got.wanted  = out_tdata[15:8];
      got.changed = out_tdata[16];
      got.step    = out_tdata[48:17];
      got.total   = out_tdata[96:49];
      if (expected_reports.size() == 0) begin
        $error("unexpected result: applied_speed %0d, wanted_speed %0d",
               got.applied, got.wanted);
        fail_count++;
      end else begin
        exp_rep = expected_reports.pop_front();
        if (got.applied != exp_rep.applied) begin
          $error("applied_speed: expected %0d, actual %0d", exp_rep.applied, got.applied);
          fail_count++;
        end
        if (got.wanted != exp_rep.wanted) begin
          $error("wanted_speed: expected %0d, actual %0d", exp_rep.wanted, got.wanted);
          fail_count++;
        end
        if (got.changed != exp_rep.changed) begin
          $error("speed_changed: expected %0d, actual %0d", exp_rep.changed, got.changed);
          fail_count++;
        end
        if (got.step != exp_rep.step) begin
          $error("volume_step: expected %0d, actual %0d", exp_rep.step, got.step);
          fail_count++;
        end
        if (got.total != exp_rep.total) begin
          $error("volume_total: expected %0d, actual %0d", exp_rep.total, got.total);
          fail_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Shared stimulus tasks
  // ---------------------------------------------------------------------

  // Offer one sample request after a random gap, hold it until accepted.
  task automatic send_sample(logic signed [TEMP_W-1:0] temp, logic [TIME_W-1:0] stamp);
    int gap;
    gap = tx_no_idle ? 0 : $urandom_range(0, MAX_PAUSE);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {{(IN_W - TEMP_W - TIME_W){1'b0}}, stamp, temp};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    expected_reports.push_back(regulate_sample(temp, stamp));
  endtask

  // Mostly samples near the setpoint so every band is hit; time mostly
  // advances around the correction interval so the gate goes both ways.
  task automatic send_random_sample();
    int t;
    int g;
    int span;
    g = band_width;
    span = 5 * g + 2;
    if ($urandom_range(0, 9) == 0) begin
      t = $signed(TEMP_W'($urandom));
    end else begin
      t = set_point + int'($urandom_range(0, 2 * span)) - span;
    end
    if (t > TEMP_MAX) t = TEMP_MAX;
    else if (t < TEMP_MIN) t = TEMP_MIN;
    case ($urandom_range(0, 19))
      0: clock_ms = $urandom;
      1: clock_ms = clock_ms + $urandom;
      default: clock_ms = clock_ms + $urandom_range(0, 2 * int'(fix_interval) + 2);
    endcase
    send_sample(t, clock_ms);
  endtask

  // Drop valid, wait for every pending result, then let the pipe settle.
  task automatic wait_for_drain();
    in_tvalid <= 1'b0;
    while (expected_reports.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Write one register; bits above the register width carry noise.
  task automatic set_reg(logic [CFG_IDX_W-1:0] idx, int value);
    logic [CFG_DATA_W-1:0] word;
    word = CFG_DATA_W'($urandom);
    case (idx)
      REG_LIMIT_ONE: begin
        word[7:0] = value[7:0];
        lim_one = value[7:0];
      end
      REG_LIMIT_TWO: begin
        word[7:0] = value[7:0];
        lim_two = value[7:0];
      end
      REG_SETPOINT: begin
        word[11:0] = value[11:0];
        set_point = $signed(value[11:0]);
      end
      REG_BAND: begin
        word[7:0] = value[7:0];
        band_width = value[7:0];
      end
      REG_INTERVAL: begin
        word = value[15:0];
        fix_interval = value[15:0];
      end
      default: ;
    endcase
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= word;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apply_settings(int l1, int l2, int sp, int bw, int iv);
    wait_for_drain();
    set_reg(REG_LIMIT_ONE, l1);
    set_reg(REG_LIMIT_TWO, l2);
    set_reg(REG_SETPOINT, sp);
    set_reg(REG_BAND, bw);
    set_reg(REG_INTERVAL, iv);
  endtask

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // Reset settings: extreme samples and stamps, step saturation, time wrap.
  task automatic test_reset_settings();
    send_sample(TEMP_MIN, 32'd20000);
    send_sample(TEMP_MAX, 32'd20000 + 32'd3_000_000_000);
    send_sample(TEMP_MIN, 32'd5);
    send_sample(TEMP_MAX, 32'hFFFF_FFFF);
    send_sample(0, 32'd0);
  endtask

  // Every band, both slopes, each edge value, and a zero elapsed time.
  task automatic test_band_edges();
    logic [TIME_W-1:0] ts;
    apply_settings(40, 200, 100, 10, 0);
    ts = last_fix_ms;
    ts++; send_sample(110, ts);   // on the +1 edge: hold, clamp lifts speed
    ts++; send_sample(111, ts);   // +1 band rising
    ts++; send_sample(50, ts);    // below -4 bands
    ts++; send_sample(121, ts);   // +2 band rising
    ts++; send_sample(120, ts);   // exactly +2 band widths, falling
    ts++; send_sample(141, ts);   // above +4 bands
    ts++; send_sample(140, ts);   // exactly +4 band widths, falling
    ts++; send_sample(90, ts);    // on the -1 edge: hold
    ts++; send_sample(89, ts);    // -1 band falling
    ts++; send_sample(79, ts);    // -2 band falling
    ts++; send_sample(80, ts);    // exactly -2 band widths, rising
    ts++; send_sample(60, ts);    // exactly -4 band widths, falling, clamps high
    send_sample(141, ts);         // same stamp: no elapsed time, no fix
  endtask

  // Largest interval, zero band, swapped limits: elapsed equal vs one over.
  task automatic test_interval_edges();
    apply_settings(0, 255, 0, 0, 65535);
    send_sample(-1, last_fix_ms + 32'd65535);
    send_sample(-1, last_fix_ms + 32'd65536);
    send_sample(1, last_fix_ms + 32'd65536);
  endtask

  // Equal limits: running speed sits outside them and gets pulled in.
  task automatic test_narrow_limits();
    apply_settings(100, 100, 0, 4, 0);
    send_sample(0, last_fix_ms + 32'd1);
    send_sample(5, last_fix_ms + 32'd2);
  endtask

  // Writes past the register list must leave the settings alone.
  task automatic test_unused_index();
    wait_for_drain();
    for (int i = REG_INTERVAL + 1; i < (1 << CFG_IDX_W); i++) begin
      set_reg(CFG_IDX_W'(i), $urandom);
    end
    clock_ms = last_fix_ms;
    repeat (2) send_random_sample();
  endtask

  // Phases of random samples under extreme and random settings.
  task automatic test_random_phases();
    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: apply_settings(0, 255, TEMP_MIN, 255, 0);
        1: apply_settings(255, 255, TEMP_MAX, 0, 65535);
        default: apply_settings($urandom_range(0, 255), $urandom_range(0, 255),
                                int'($urandom_range(0, 3600)) - 1800,
                                ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
                                                            : $urandom_range(0, 24),
                                ($urandom_range(0, 4) == 0) ? $urandom_range(0, 65535)
                                                            : $urandom_range(0, 2500));
      endcase
      // Phase 2 runs flat out on both sides; the rest pick at random.
      tx_no_idle = (phase == 2) || ($urandom_range(0, 3) == 0);
      rx_no_idle = (phase == 2) || ($urandom_range(0, 3) == 0);
      clock_ms = last_fix_ms;
      repeat (PHASE_ITEMS) send_random_sample();
    end
    tx_no_idle = 1'b0;
    rx_no_idle = 1'b0;
  endtask

  // Hold the sink off while the source streams, so the queue fills and
  // in_tready drops.
  task automatic test_backpressure();
    apply_settings(30, 220, 0, 6, 50);
    tx_no_idle = 1'b1;
    sink_hold_req = HOLD_CYCLES;
    clock_ms = last_fix_ms;
    repeat (60) send_random_sample();
    tx_no_idle = 1'b0;
  endtask

  initial begin
    reset_regulator();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_settings();
    test_band_edges();
    test_interval_edges();
    test_narrow_limits();
    test_unused_index();
    test_random_phases();
    test_backpressure();

    wait_for_drain();
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Watchdog far beyond the slowest correct run.
  initial begin
    #2000000;
    $display("status: fail");
    $finish;
  end

endmodule

`default_nettype wire
